/* hdl/adq_pkg.sv */
// adq_pkg: shared constants and types for the array deque
`timescale 1ns / 1ps
package adq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CAP_W = 7;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT = 3'd2;
  localparam logic [2:0] CMD_POP_BACK = 3'd3;
  localparam logic [2:0] CMD_LIST = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVER = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  localparam logic [2:0] OP_HOLD = 3'd0;
  localparam logic [2:0] OP_SHR = 3'd1;
  localparam logic [2:0] OP_SHL = 3'd2;
  localparam logic [2:0] OP_WR = 3'd3;
  localparam logic [2:0] OP_ROT = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic wr_here;
    logic is_last;
  } cell_ctl_t;

endpackage

/* hdl/adq_req_if.sv */
// adq_req_if: command channel of the array deque
`timescale 1ns / 1ps
interface adq_req_if;
  logic valid;
  logic ready;
  logic [2:0] command;
  logic signed [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

/* hdl/adq_rsp_if.sv */
// adq_rsp_if: result channel of the array deque
`timescale 1ns / 1ps
interface adq_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic signed [31:0] value_res;
  logic last;

  modport source (output valid, output status, output value_res, output last, input ready);
  modport sink (input valid, input status, input value_res, input last, output ready);
endinterface

/* hdl/adq_cfg_if.sv */
// adq_cfg_if: capacity register write channel of the array deque
`timescale 1ns / 1ps
interface adq_cfg_if;
  logic valid;
  logic ready;
  logic [6:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/adq_cell.sv */
// adq_cell: one storage cell of the deque chain
`timescale 1ns / 1ps
module adq_cell
  import adq_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic signed [DATA_W-1:0] head_data,
  input  logic signed [DATA_W-1:0] tap_in,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] tap_out
);

  logic signed [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.op)
      OP_HOLD: data_next = data;
      OP_SHR:  data_next = left_data;
      OP_SHL:  data_next = right_data;
      OP_WR: begin
        if (ctl.wr_here) data_next = push_value;
      end
      // the tail cell closes the ring by taking the head element
      OP_ROT:  data_next = ctl.is_last ? head_data : right_data;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign tap_out = tap_in | (ctl.is_last ? data : '0);

endmodule

/* hdl/array_deque.sv */
// array_deque: bounded double-ended queue built as a chain of cells
//
// Commands arrive on req (command, value); results leave on rsp (status,
// value_res, last). The capacity register is written through cfg, which is
// always ready; write it only while the block is idle.
// Elements sit packed in a row of DEPTH cells, front in cell 0. A push at
// front or a pop at front shifts the whole row by one cell; a push at back
// writes the cell just past the tail; a pop at back reads the tail cell.
// Push and pop: the result is registered and appears in the cycle after
// the accepting beat; a new command is taken each cycle while rsp keeps up.
// List: one result beat per held element; the accepting cycle starts the list
// state, which then gives the beats; the row rotates by one cell per beat and
// is back in place after the last beat.
// Commands 5 to 7 are taken and give no result.
// Reset empties the deque and sets capacity to 16; cell contents are not
// cleared. While rsp stalls the pending result holds and req is not ready.
`timescale 1ns / 1ps
module array_deque
  import adq_pkg::*;
(
  input logic clk,
  input logic rst,
  adq_req_if.sink   req,
  adq_rsp_if.source rsp,
  adq_cfg_if.sink   cfg
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic state;
  logic state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] list_idx;
  logic [CNT_W-1:0] list_idx_next;
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] limit;

  logic ovalid;
  logic ovalid_next;
  logic [1:0] ostatus;
  logic [1:0] ostatus_next;
  logic signed [DATA_W-1:0] ovalue;
  logic signed [DATA_W-1:0] ovalue_next;
  logic olast;
  logic olast_next;

  logic out_free;
  logic req_acc;
  logic full;
  logic empty;
  logic [2:0] op;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] cell_tap [DEPTH];
  cell_ctl_t cell_ctl [DEPTH];

  assign out_free = !ovalid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign req_acc = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign limit = (capacity > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : capacity;
  assign full = CAP_W'(count) >= limit;
  assign empty = (count == '0);

  always_comb begin
    state_next = state;
    count_next = count;
    list_idx_next = list_idx;
    ovalid_next = ovalid && !rsp.ready;
    ostatus_next = ostatus;
    ovalue_next = ovalue;
    olast_next = olast;
    op = OP_HOLD;

    if (req_acc) begin
      ostatus_next = ST_OK;
      ovalue_next = '0;
      olast_next = 1'b1;
      ovalid_next = 1'b1;
      case (req.command)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (full) begin
            ostatus_next = ST_OVER;
          end else begin
            op = (req.command == CMD_PUSH_FRONT) ? OP_SHR : OP_WR;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (empty) begin
            ostatus_next = ST_UNDER;
          end else begin
            if (req.command == CMD_POP_FRONT) begin
              op = OP_SHL;
              ovalue_next = cell_data[0];
            end else begin
              ovalue_next = cell_tap[0];
            end
            count_next = count - CNT_W'(1);
          end
        end
        CMD_LIST: begin
          if (empty) begin
            ostatus_next = ST_UNDER;
          end else begin
            // list beats come from the list state
            ovalid_next = 1'b0;
            state_next = S_LIST;
            list_idx_next = '0;
          end
        end
        default: begin
          ovalid_next = 1'b0;
        end
      endcase
    end else if (state == S_LIST && out_free) begin
      op = OP_ROT;
      ovalid_next = 1'b1;
      ostatus_next = ST_OK;
      ovalue_next = cell_data[0];
      olast_next = (list_idx + CNT_W'(1)) == count;
      list_idx_next = list_idx + CNT_W'(1);
      if (olast_next) state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      list_idx <= '0;
      ovalid <= 1'b0;
      capacity <= CAP_W'(16);
    end else begin
      state <= state_next;
      count <= count_next;
      list_idx <= list_idx_next;
      ovalid <= ovalid_next;
      if (cfg.valid && cfg.ready) capacity <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    ostatus <= ostatus_next;
    ovalue <= ovalue_next;
    olast <= olast_next;
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_d;
      logic signed [DATA_W-1:0] right_d;
      logic signed [DATA_W-1:0] tap_i;

      assign cell_ctl[i].op = op;
      assign cell_ctl[i].wr_here = (count == CNT_W'(i));
      assign cell_ctl[i].is_last = (count == CNT_W'(i + 1));

      if (i == 0) begin : g_first
        assign left_d = req.value;
      end else begin : g_mid
        assign left_d = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
        assign right_d = '0;
        assign tap_i = '0;
      end else begin : g_inner
        assign right_d = cell_data[i+1];
        assign tap_i = cell_tap[i+1];
      end

      adq_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .push_value (req.value),
        .left_data  (left_d),
        .right_data (right_d),
        .head_data  (cell_data[0]),
        .tap_in     (tap_i),
        .data       (cell_data[i]),
        .tap_out    (cell_tap[i])
      );
    end
  endgenerate

  assign rsp.valid = ovalid;
  assign rsp.status = ostatus;
  assign rsp.value_res = ovalue;
  assign rsp.last = olast;

`ifndef ASSERT_OFF
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    req_acc && empty &&
    (req.command == CMD_POP_FRONT || req.command == CMD_POP_BACK)
    |=> ovalid && ostatus == ST_UNDER && olast)
    else $error("pop on empty deque did not report underflow");

  a_list_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_LIST |-> list_idx < count)
    else $error("list index ran past the element count");

  a_not_last: assert property (@(posedge clk) disable iff (rst)
    ovalid && !olast |-> state == S_LIST)
    else $error("non-final result beat outside a list");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    req_acc && full &&
    (req.command == CMD_PUSH_FRONT || req.command == CMD_PUSH_BACK)
    |=> count == $past(count))
    else $error("count changed on a push to a full deque");
`endif

endmodule
